// ===== hdl/cnvn_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cnvn_pkg
// Shared widths and types for the cell normal vector normaliser.
// ---------------------------------------------------------------------------
package cnvn_pkg;

  localparam int unsigned IN_W     = 32;             // input field width
  localparam int unsigned QW       = IN_W + 16;      // quotient magnitude width
  localparam int unsigned SUMW     = 2 * QW;         // sum of squares width
  localparam int unsigned RTW      = QW;             // square root width
  localparam int unsigned NW       = RTW + 1;        // norm width
  localparam int unsigned FRAC     = 16;             // output fraction bits
  localparam int unsigned OUT_W    = FRAC + 2;       // output field width
  localparam int unsigned EPS_W    = 16;
  localparam int unsigned HALF_W   = QW / 2;
  localparam int unsigned IN_TD_W  = 6 * IN_W;
  localparam int unsigned OUT_TD_W = ((3 * OUT_W + 7) / 8) * 8;
  localparam int unsigned CFG_AW   = 2;

  localparam logic [CFG_AW-1:0] REG_EPS_ADDR = '0;
  localparam logic [EPS_W-1:0]  EPS_RESET    = EPS_W'(1);
  localparam logic [QW-1:0]     QUOT_MAX     = QW'(1) << (QW - 1);

  // sideband that rides alongside the square root
  typedef struct packed {
    logic [2:0][QW-1:0] qm;
    logic [2:0]         neg;
  } side_t;

  // one step of the square root recurrence
  typedef struct packed {
    logic [RTW+1:0]  rem;
    logic [RTW-1:0]  root;
    logic [SUMW-1:0] s;
  } sqst_t;

endpackage

`default_nettype wire

// ===== hdl/cnvn_sqrt.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cnvn_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ---------------------------------------------------------------------------
module cnvn_sqrt (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_vld,
  input  wire logic [cnvn_pkg::SUMW-1:0] in_sum,
  input  wire cnvn_pkg::side_t         in_side,
  output logic                         out_vld,
  output logic [cnvn_pkg::RTW-1:0]     out_root,
  output cnvn_pkg::side_t              out_side
);
  import cnvn_pkg::*;

  sqst_t st_r   [0:RTW-1];
  sqst_t st_nxt [0:RTW-1];
  side_t sd_r   [0:RTW-1];
  logic  [RTW-1:0] vld_r;

  function automatic sqst_t sq_step(sqst_t a);
    logic [RTW+3:0] t;
    logic [RTW+3:0] trial;
    sqst_t          o;
    t     = {a.rem, a.s[SUMW-1 -: 2]};
    trial = {2'b00, a.root, 2'b01};
    o.s   = {a.s[SUMW-3:0], 2'b00};
    if (t >= trial) begin
      o.rem  = (RTW+2)'(t - trial);
      o.root = {a.root[RTW-2:0], 1'b1};
    end else begin
      o.rem  = t[RTW+1:0];
      o.root = {a.root[RTW-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    sqst_t init;
    init.rem  = '0;
    init.root = '0;
    init.s    = in_sum;
    st_nxt[0] = sq_step(init);
    for (int k = 1; k < RTW; k++) begin
      st_nxt[k] = sq_step(st_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[RTW-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st_nxt[0];
      sd_r[0] <= in_side;
      for (int k = 1; k < RTW; k++) begin
        st_r[k] <= st_nxt[k];
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  assign out_vld  = vld_r[RTW-1];
  assign out_root = st_r[RTW-1].root;
  assign out_side = sd_r[RTW-1];

endmodule

`default_nettype wire

// ===== hdl/cell_normal_vector_normalize.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cell_normal_vector_normalize
// Scales a cell gradient by the cell sizes and normalises it to unit length.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one word per grid cell, the three gradient components and the
//           three cell sizes. out_* : one word per cell, the three signed
//           Q1.16 unit-normal components.
//   cfg_* : APB-style port holding magnitude_epsilon at byte address 0.
// out_tvalid trails the handshake by 120 register stages. A new word is
// taken every cycle outside receiver stalls: the per-axis divide (a setup
// stage and 48 stages, one quotient bit each), four square and sum stages,
// the square root (48 stages, one root bit each), the norm stage, the final
// divide (17 stages) and the output register are fully pipelined.
// When the receiver stalls with a word waiting, the whole pipeline freezes
// and in_tready drops; bubbles keep moving while out_tvalid is low.
// Reset empties the pipeline and sets magnitude_epsilon to 1.
// ---------------------------------------------------------------------------
module cell_normal_vector_normalize (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // grad_x, grad_y, grad_z, cell_size_x, cell_size_y, cell_size_z
  input  wire logic [cnvn_pkg::IN_TD_W-1:0]  in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // normal_x, normal_y, normal_z, zero pad
  output logic [cnvn_pkg::OUT_TD_W-1:0]      out_tdata,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [cnvn_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import cnvn_pkg::*;

  typedef struct packed {
    logic [IN_W-1:0] r;
    logic [QW-1:0]   q;
    logic [IN_W-1:0] mag;
    logic [IN_W-1:0] size;
    logic            ovf;
    logic            neg;
  } dlane_t;

  typedef struct packed {
    logic [NW:0]   r;
    logic [FRAC:0] res;
  } flane_t;

  logic             en;
  logic [EPS_W-1:0] eps_r;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_EPS_ADDR) ? {{(32-EPS_W){1'b0}}, eps_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_EPS_ADDR) begin
      eps_r <= cfg_pwdata[EPS_W-1:0];
    end
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- per-axis divide ----------------
  dlane_t d_r   [0:QW][0:2];
  dlane_t d_nxt [0:QW][0:2];
  logic   [QW:0] dv_r;
  logic   [QW:0] draw_r;

  function automatic dlane_t div_step(dlane_t a, int unsigned k);
    logic [IN_W:0] rs;
    logic          db;
    dlane_t        o;
    o  = a;
    db = (k < 16) ? a.mag[4'(15 - k)] : 1'b0;
    rs = {a.r, db};
    if (rs >= {1'b0, a.size}) begin
      o.r = IN_W'(rs - {1'b0, a.size});
      o.q = {a.q[QW-2:0], 1'b1};
    end else begin
      o.r = rs[IN_W-1:0];
      o.q = {a.q[QW-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    logic [IN_W-1:0] g;
    for (int l = 0; l < 3; l++) begin
      g               = in_tdata[IN_W*l +: IN_W];
      d_nxt[0][l].neg = g[IN_W-1];
      d_nxt[0][l].mag = g[IN_W-1] ? IN_W'(-g) : g;
      d_nxt[0][l].size = in_tdata[IN_W*(3+l) +: IN_W];
      d_nxt[0][l].ovf = {16'b0, d_nxt[0][l].mag[IN_W-1:16]} >= d_nxt[0][l].size;
      d_nxt[0][l].r   = {16'b0, d_nxt[0][l].mag[IN_W-1:16]};
      d_nxt[0][l].q   = '0;
    end
    for (int k = 0; k < QW; k++) begin
      for (int l = 0; l < 3; l++) begin
        d_nxt[k+1][l] = div_step(d_r[k][l], k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (en) begin
      dv_r <= {dv_r[QW-1:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      draw_r <= {draw_r[QW-1:0], (in_tdata[IN_W*3 +: IN_W] == '0) ||
                 (in_tdata[IN_W*4 +: IN_W] == '0) || (in_tdata[IN_W*5 +: IN_W] == '0)};
      for (int k = 0; k <= QW; k++) begin
        for (int l = 0; l < 3; l++) begin
          d_r[k][l] <= d_nxt[k][l];
        end
      end
    end
  end

  // ---------------- squares and sum ----------------
  side_t            s1_r, s2_r, s3_r, s4_r;
  logic             s1v_r, s2v_r, s3v_r, s4v_r;
  logic [2:0][QW-1:0]   hh_r, hl_r, ll_r;
  logic [2:0][SUMW-1:0] sq_r;
  logic [SUMW-1:0]      sum_r;
  side_t                s1_nxt;

  always_comb begin
    dlane_t f;
    for (int l = 0; l < 3; l++) begin
      f               = d_r[QW][l];
      s1_nxt.neg[l]   = f.neg;
      if (draw_r[QW]) begin
        s1_nxt.qm[l] = {f.mag, 16'b0};
      end else if (f.ovf || f.q > QUOT_MAX) begin
        s1_nxt.qm[l] = QUOT_MAX;
      end else begin
        s1_nxt.qm[l] = f.q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1v_r <= 1'b0;
      s2v_r <= 1'b0;
      s3v_r <= 1'b0;
      s4v_r <= 1'b0;
    end else if (en) begin
      s1v_r <= dv_r[QW];
      s2v_r <= s1v_r;
      s3v_r <= s2v_r;
      s4v_r <= s3v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s1_r;
      s3_r <= s2_r;
      s4_r <= s3_r;
      for (int l = 0; l < 3; l++) begin
        hh_r[l] <= s1_r.qm[l][QW-1:HALF_W] * s1_r.qm[l][QW-1:HALF_W];
        hl_r[l] <= s1_r.qm[l][QW-1:HALF_W] * s1_r.qm[l][HALF_W-1:0];
        ll_r[l] <= s1_r.qm[l][HALF_W-1:0] * s1_r.qm[l][HALF_W-1:0];
        sq_r[l] <= ({hh_r[l], {QW{1'b0}}}) +
                   ({{(HALF_W-1){1'b0}}, hl_r[l], {(HALF_W+1){1'b0}}}) +
                   ({{QW{1'b0}}, ll_r[l]});
      end
      sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  // ---------------- square root ----------------
  logic           rt_vld;
  logic [RTW-1:0] rt_root;
  side_t          rt_side;

  cnvn_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s4v_r),
    .in_sum   (sum_r),
    .in_side  (s4_r),
    .out_vld  (rt_vld),
    .out_root (rt_root),
    .out_side (rt_side)
  );

  // ---------------- norm and final divide ----------------
  logic [NW-1:0] nm_r;
  logic          nmv_r;
  side_t         nms_r;

  flane_t        f_r   [0:FRAC][0:2];
  flane_t        f_nxt [0:FRAC][0:2];
  logic [NW-1:0] fn_r  [0:FRAC];
  logic [2:0]    fneg_r [0:FRAC];
  logic [FRAC:0] fv_r;

  function automatic flane_t frac_step(flane_t a, logic [NW-1:0] n, int unsigned k);
    logic [NW:0] t;
    flane_t      o;
    t = (k == 0) ? a.r : {a.r[NW-1:0], 1'b0};
    if (t >= {1'b0, n}) begin
      o.r   = t - {1'b0, n};
      o.res = {a.res[FRAC-1:0], 1'b1};
    end else begin
      o.r   = t;
      o.res = {a.res[FRAC-1:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    flane_t init;
    for (int l = 0; l < 3; l++) begin
      init.r      = {2'b00, nms_r.qm[l]};
      init.res    = '0;
      f_nxt[0][l] = frac_step(init, nm_r, 0);
      for (int k = 1; k <= FRAC; k++) begin
        f_nxt[k][l] = frac_step(f_r[k-1][l], fn_r[k-1], k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nmv_r <= 1'b0;
      fv_r  <= '0;
    end else if (en) begin
      nmv_r <= rt_vld;
      fv_r  <= {fv_r[FRAC-1:0], nmv_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_r      <= {1'b0, rt_root} + {{(NW-EPS_W){1'b0}}, eps_r};
      nms_r     <= rt_side;
      fn_r[0]   <= nm_r;
      fneg_r[0] <= nms_r.neg;
      for (int k = 1; k <= FRAC; k++) begin
        fn_r[k]   <= fn_r[k-1];
        fneg_r[k] <= fneg_r[k-1];
      end
      for (int k = 0; k <= FRAC; k++) begin
        for (int l = 0; l < 3; l++) begin
          f_r[k][l] <= f_nxt[k][l];
        end
      end
    end
  end

  // ---------------- output register ----------------
  logic [2:0][OUT_W-1:0] o_r;
  logic                  ov_r;
  logic [2:0][OUT_W-1:0] o_nxt;

  always_comb begin
    logic [OUT_W-1:0] m;
    for (int l = 0; l < 3; l++) begin
      m        = (fn_r[FRAC] == '0) ? '0 : {1'b0, f_r[FRAC][l].res};
      o_nxt[l] = fneg_r[FRAC][l] ? OUT_W'(-m) : m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= fv_r[FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_r <= o_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {{(OUT_TD_W-3*OUT_W){1'b0}}, o_r[2], o_r[1], o_r[0]};

endmodule

`default_nettype wire
